// ===== rtl/core/som_pkg.sv =====
// ----------------------------------------------------------------------------
// som_pkg
// Shared constants, codes and tables of the self-organizing map block.
// ----------------------------------------------------------------------------
package som_pkg;

  localparam int unsigned MaxInputs  = 8;
  localparam int unsigned MaxRows    = 16;
  localparam int unsigned MaxCols    = 16;
  localparam int unsigned DataWidth  = 16;
  localparam int unsigned Neurons    = MaxRows * MaxCols;
  localparam int unsigned WeightDepth = Neurons * MaxInputs;

  // Input kinds
  localparam logic [1:0] KIND_LOAD     = 2'd0;
  localparam logic [1:0] KIND_TRAIN    = 2'd1;
  localparam logic [1:0] KIND_CLASSIFY = 2'd2;

  // Register indexes
  localparam logic [2:0] CFG_VECTOR_LENGTH = 3'd0;
  localparam logic [2:0] CFG_MAP_ROWS      = 3'd1;
  localparam logic [2:0] CFG_MAP_COLS      = 3'd2;
  localparam logic [2:0] CFG_START_ALPHA   = 3'd3;
  localparam logic [2:0] CFG_ALPHA_DECAY   = 3'd4;
  localparam logic [2:0] CFG_START_RADIUS  = 3'd5;
  localparam logic [2:0] CFG_RADIUS_DECAY  = 3'd6;

  // Request to the neighborhood gain unit
  typedef struct packed {
    logic        start;
    logic [20:0] root;   // floor(sqrt(d2) * 2^16)
    logic [16:0] rr;     // 2 * r^2
    logic [15:0] alpha;  // Q0.16
  } theta_req_t;

  typedef logic [20:0] sqrt_lut_t [256];

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned rem;
    res  = 0;
    rem  = v;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Index {|di|, |dj|}: floor(sqrt(di^2 + dj^2) * 2^16)
  function automatic sqrt_lut_t build_sqrt_lut();
    sqrt_lut_t t;
    longint unsigned d2;
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 16; j++) begin
        d2 = longint'(i * i + j * j);
        t[i * 16 + j] = 21'(isqrt(d2 << 32));
      end
    end
    return t;
  endfunction

  localparam sqrt_lut_t SQRT_LUT = build_sqrt_lut();

endpackage

// ===== rtl/core/som_winner_and_train.sv =====
// ----------------------------------------------------------------------------
// som_winner_and_train
// Self-organizing map: best-matching neuron search and neighborhood training.
// ----------------------------------------------------------------------------
// Weights (Q8.8) live in one 2048 x 16 RAM, eight words per neuron. A load
// beat writes one weight. Train and classify beats fill the vector buffer
// one element per cycle; the beat with last set starts the search, which
// streams rows*cols*n weights through the RAM read port, one per cycle. A
// train vector then walks the window around the winner: per neuron the
// serial gain divider, then a read, multiply and write per element, and at
// the end the decay of alpha and radius. The input is not ready while a
// vector is processed; a finished result waits in the output register and
// does not hold up the next input beat unless the register still holds an
// untaken result. Configuration writes take effect at once and are meant
// for an idle block.
// ----------------------------------------------------------------------------
module som_winner_and_train (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  neuron_i,
  input  logic [2:0]  element_i,
  input  logic [15:0] value_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  winner_index_o,
  output logic        was_training_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_SDRAIN = 4'd2;
  localparam logic [3:0] S_WIN    = 4'd3;
  localparam logic [3:0] S_NBR    = 4'd4;
  localparam logic [3:0] S_THETA  = 4'd5;
  localparam logic [3:0] S_URD    = 4'd6;
  localparam logic [3:0] S_UMUL   = 4'd7;
  localparam logic [3:0] S_UWR    = 4'd8;
  localparam logic [3:0] S_DECAY  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  // Configuration
  logic [3:0]  vlen_q;
  logic [4:0]  rows_q, cols_q;
  logic [15:0] adecay_q, rdecay_q;
  logic [15:0] alpha_q;
  logic [23:0] rexact_q;
  logic [7:0]  rnow_q;

  logic [3:0] n_eff;
  logic [4:0] rows_eff, cols_eff;

  assign n_eff    = (vlen_q == 4'd0) ? 4'd1 : (vlen_q > 4'd8) ? 4'd8 : vlen_q;
  assign rows_eff = (rows_q == 5'd0) ? 5'd1 : (rows_q > 5'd16) ? 5'd16 : rows_q;
  assign cols_eff = (cols_q == 5'd0) ? 5'd1 : (cols_q > 5'd16) ? 5'd16 : cols_q;

  // Sequencer
  logic [3:0] state_q, state_d;
  logic       mode_q;                  // 1 for a train vector
  logic [2:0] k_q;
  logic [7:0] idx_q;
  logic [3:0] row_q, col_q;

  // Search data stage tag
  logic       tvld_q;
  logic [2:0] tk_q;
  logic       tlast_q;
  logic [7:0] tidx_q;
  logic [3:0] trow_q, tcol_q;

  logic [35:0] acc_q, bestd_q;
  logic [7:0]  best_q;
  logic [3:0]  brow_q, bcol_q;

  // Window walk
  logic [3:0]  r0_q, r1_q, c0_q, c1_q, a_q, b_q;
  logic [7:0]  uidx_q;
  logic [15:0] w_q;
  logic signed [34:0] prod_q;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_idx_q;
  logic       out_train_q;

  // Vector buffer
  logic [15:0] vbuf_q [som_pkg::MaxInputs];
  logic [2:0]  vsel;
  logic [15:0] xv;

  // RAM ports
  logic        ram_we;
  logic [10:0] ram_waddr, ram_raddr;
  logic [15:0] ram_wdata, ram_rdata;

  // Gain unit
  som_pkg::theta_req_t th_req;
  logic                th_done;
  logic [16:0]         th_ta;

  logic in_acc;
  logic k_end;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign k_end      = ({1'b0, k_q} == 4'(n_eff - 4'd1));

  assign vsel = (state_q == S_SEARCH || state_q == S_SDRAIN) ? tk_q : k_q;
  assign xv   = vbuf_q[vsel];

  // Search distance accumulation
  logic signed [16:0] sdiff;
  logic signed [33:0] ssq;
  logic [35:0]        ssum;
  assign sdiff = $signed({ram_rdata[15], ram_rdata}) - $signed({xv[15], xv});
  assign ssq   = sdiff * sdiff;
  assign ssum  = acc_q + {2'b00, ssq[33:0]};

  // Window bounds around the winner
  logic signed [9:0] lo_r, lo_c;
  logic [8:0]        hi_r, hi_c;
  assign lo_r = $signed({6'd0, brow_q}) - $signed({2'd0, rnow_q});
  assign lo_c = $signed({6'd0, bcol_q}) - $signed({2'd0, rnow_q});
  assign hi_r = {5'd0, brow_q} + {1'b0, rnow_q};
  assign hi_c = {5'd0, bcol_q} + {1'b0, rnow_q};

  // Offsets to the winner
  logic [3:0] di, dj;
  logic [8:0] uidx_full;
  assign di = (a_q >= brow_q) ? 4'(a_q - brow_q) : 4'(brow_q - a_q);
  assign dj = (b_q >= bcol_q) ? 4'(b_q - bcol_q) : 4'(bcol_q - b_q);
  assign uidx_full = 9'(a_q * cols_eff) + {5'd0, b_q};

  always_comb begin
    th_req.start = (state_q == S_NBR);
    th_req.root  = som_pkg::SQRT_LUT[{di, dj}];
    // r^2 needs the full 16 bits before the doubling shift
    th_req.rr    = {{8'd0, rnow_q} * {8'd0, rnow_q}, 1'b0};
    th_req.alpha = alpha_q;
  end

  // Weight update arithmetic
  logic signed [16:0] udiff;
  logic signed [34:0] uprod;
  logic signed [34:0] urnd;
  logic signed [19:0] usum;
  logic [15:0]        unew;
  assign udiff = $signed({xv[15], xv}) - $signed({ram_rdata[15], ram_rdata});
  assign uprod = $signed({1'b0, th_ta}) * udiff;
  assign urnd  = prod_q + 35'sd32768;
  assign usum  = $signed({{4{w_q[15]}}, w_q}) + $signed(urnd[34:16]);
  always_comb begin
    if (usum > 20'sd32767) begin
      unew = 16'h7fff;
    end else if (usum < -20'sd32768) begin
      unew = 16'h8000;
    end else begin
      unew = usum[15:0];
    end
  end

  // Decay
  logic [32:0] anext;
  logic [40:0] rnext;
  logic [8:0]  rint;
  assign anext = 33'(alpha_q * adecay_q) + 33'd32768;
  assign rnext = 41'(rexact_q * rdecay_q) + 41'd32768;
  assign rint  = {1'b0, rnext[39:32]} + 9'd1;

  // RAM port muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {neuron_i, element_i};
    ram_wdata = value_i;
    ram_raddr = {idx_q, k_q};
    if (in_acc && kind_i == som_pkg::KIND_LOAD) begin
      ram_we = 1'b1;
    end
    if (state_q == S_UWR) begin
      ram_we    = 1'b1;
      ram_waddr = {uidx_q, k_q};
      ram_wdata = unew;
    end
    if (state_q == S_URD) begin
      ram_raddr = {uidx_q, k_q};
    end
  end

  som_ram #(
    .Width (som_pkg::DataWidth),
    .Depth (som_pkg::WeightDepth)
  ) u_weights (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  som_theta u_theta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (th_req),
    .done_o (th_done),
    .ta_o   (th_ta)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && last_i &&
            (kind_i == som_pkg::KIND_TRAIN || kind_i == som_pkg::KIND_CLASSIFY)) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (k_end && {1'b0, row_q} == 5'(rows_eff - 5'd1) &&
            {1'b0, col_q} == 5'(cols_eff - 5'd1)) begin
          state_d = S_SDRAIN;
        end
      end
      S_SDRAIN: state_d = mode_q ? S_WIN : S_OUT;
      S_WIN:    state_d = S_NBR;
      S_NBR:    state_d = S_THETA;
      S_THETA:  state_d = th_done ? S_URD : S_THETA;
      S_URD:    state_d = S_UMUL;
      S_UMUL:   state_d = S_UWR;
      S_UWR: begin
        if (!k_end) begin
          state_d = S_URD;
        end else if (b_q == c1_q && a_q == r1_q) begin
          state_d = S_DECAY;
        end else begin
          state_d = S_NBR;
        end
      end
      S_DECAY: state_d = S_OUT;
      S_OUT:   state_d = (!out_valid_q || out_ready_i) ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      tvld_q      <= 1'b0;
      vlen_q      <= 4'd2;
      rows_q      <= 5'd16;
      cols_q      <= 5'd16;
      adecay_q    <= 16'd65500;
      rdecay_q    <= 16'd65500;
      alpha_q     <= 16'd32768;
      rexact_q    <= {8'd4, 16'd0};
      rnow_q      <= 8'd4;
    end else begin
      state_q <= state_d;
      tvld_q  <= (state_q == S_SEARCH);

      // Load a new result, or drop the one just taken
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          som_pkg::CFG_VECTOR_LENGTH: vlen_q <= cfg_data_i[3:0];
          som_pkg::CFG_MAP_ROWS:      rows_q <= cfg_data_i[4:0];
          som_pkg::CFG_MAP_COLS:      cols_q <= cfg_data_i[4:0];
          som_pkg::CFG_START_ALPHA:   alpha_q <= cfg_data_i;
          som_pkg::CFG_ALPHA_DECAY:   adecay_q <= cfg_data_i;
          som_pkg::CFG_START_RADIUS: begin
            rexact_q <= {3'd0, cfg_data_i[4:0], 16'd0};
            rnow_q   <= {3'd0, cfg_data_i[4:0]};
          end
          som_pkg::CFG_RADIUS_DECAY:  rdecay_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == S_DECAY) begin
        alpha_q  <= anext[31:16];
        rexact_q <= rnext[39:16];
        rnow_q   <= rint[8] ? 8'd255 : rint[7:0];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (kind_i == som_pkg::KIND_TRAIN || kind_i == som_pkg::KIND_CLASSIFY)) begin
      vbuf_q[element_i] <= value_i;
      mode_q <= (kind_i == som_pkg::KIND_TRAIN);
      k_q    <= 3'd0;
      idx_q  <= 8'd0;
      row_q  <= 4'd0;
      col_q  <= 4'd0;
      acc_q  <= 36'd0;
    end

    // Issue stage: advance through neurons, element inner
    if (state_q == S_SEARCH) begin
      tk_q    <= k_q;
      tlast_q <= k_end;
      tidx_q  <= idx_q;
      trow_q  <= row_q;
      tcol_q  <= col_q;
      if (k_end) begin
        k_q   <= 3'd0;
        idx_q <= idx_q + 8'd1;
        if ({1'b0, col_q} == 5'(cols_eff - 5'd1)) begin
          col_q <= 4'd0;
          row_q <= row_q + 4'd1;
        end else begin
          col_q <= col_q + 4'd1;
        end
      end else begin
        k_q <= k_q + 3'd1;
      end
    end

    // Data stage: accumulate and compare; ties go to the later neuron
    if (tvld_q) begin
      if (tlast_q) begin
        acc_q <= 36'd0;
        if (tidx_q == 8'd0 || ssum <= bestd_q) begin
          bestd_q <= ssum;
          best_q  <= tidx_q;
          brow_q  <= trow_q;
          bcol_q  <= tcol_q;
        end
      end else begin
        acc_q <= ssum;
      end
    end

    if (state_q == S_WIN) begin
      r0_q <= lo_r[9] ? 4'd0 : lo_r[3:0];
      c0_q <= lo_c[9] ? 4'd0 : lo_c[3:0];
      r1_q <= (hi_r < {4'd0, rows_eff}) ? hi_r[3:0] : 4'(rows_eff - 5'd1);
      c1_q <= (hi_c < {4'd0, cols_eff}) ? hi_c[3:0] : 4'(cols_eff - 5'd1);
      a_q  <= lo_r[9] ? 4'd0 : lo_r[3:0];
      b_q  <= lo_c[9] ? 4'd0 : lo_c[3:0];
    end

    if (state_q == S_NBR) begin
      uidx_q <= uidx_full[7:0];
      k_q    <= 3'd0;
    end

    if (state_q == S_UMUL) begin
      w_q    <= ram_rdata;
      prod_q <= uprod;
    end

    if (state_q == S_UWR) begin
      if (!k_end) begin
        k_q <= k_q + 3'd1;
      end else if (b_q == c1_q) begin
        b_q <= c0_q;
        a_q <= a_q + 4'd1;
      end else begin
        b_q <= b_q + 4'd1;
      end
    end

    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      out_idx_q   <= best_q;
      out_train_q <= mode_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign winner_index_o = out_idx_q;
  assign was_training_o = out_train_q;

  // The search owns the RAM: no write may land in its stream
  a_no_write_in_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH || state_q == S_SDRAIN) |-> !ram_we)
    else $error("weight write during winner search");

  // The gain unit reports only to a waiting sequencer
  a_theta_done_waited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    th_done |-> state_q == S_THETA)
    else $error("gain unit finished outside the wait state");

  // The winner found by the search lies on the map in use
  a_winner_on_map : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WIN |-> ({1'b0, brow_q} < rows_eff && {1'b0, bcol_q} < cols_eff))
    else $error("winner outside the map");

  // Search data stage follows only a search issue cycle
  a_tag_follows_issue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tvld_q |-> $past(state_q) == S_SEARCH)
    else $error("search data stage without issue");

endmodule

// ===== rtl/core/som_ram.sv =====
// ----------------------------------------------------------------------------
// som_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module som_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/som_theta.sv =====
// ----------------------------------------------------------------------------
// som_theta
// Neighborhood gain: ta = round(theta * alpha), theta = 1 - root / rr,
// with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module som_theta (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  som_pkg::theta_req_t req_i,
  output logic                done_o,
  output logic [16:0]         ta_o
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_DIV  = 2'd1;
  localparam logic [1:0] T_MUL  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [20:0] num_q, num_d;
  logic [16:0] rr_q, rr_d;
  logic [15:0] alpha_q, alpha_d;
  logic [16:0] rem_q, rem_d;
  logic [20:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        zero_q, zero_d;
  logic        done_q, done_d;
  logic [16:0] ta_q, ta_d;

  logic [17:0] rem_sh;
  logic [16:0] theta;
  logic [33:0] prod;

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rr_d    = rr_q;
    alpha_d = alpha_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    zero_d  = zero_q;
    done_d  = 1'b0;
    ta_d    = ta_q;
    rem_sh  = {rem_q, num_q[20]};
    theta   = 17'd0;
    if (zero_q) begin
      theta = 17'h10000;
    end else if (quo_q[20:16] == 5'd0) begin
      theta = 17'h10000 - {1'b0, quo_q[15:0]};
    end
    prod = 34'(theta * alpha_q) + 34'd32768;

    case (state_q)
      T_IDLE: begin
        if (req_i.start) begin
          num_d   = req_i.root;
          rr_d    = req_i.rr;
          alpha_d = req_i.alpha;
          rem_d   = 17'd0;
          quo_d   = 21'd0;
          cnt_d   = 5'd20;
          zero_d  = (req_i.rr == 17'd0);
          state_d = (req_i.rr == 17'd0) ? T_MUL : T_DIV;
        end
      end
      T_DIV: begin
        // one quotient bit per cycle
        if (rem_sh >= {1'b0, rr_q}) begin
          rem_d = 17'(rem_sh - {1'b0, rr_q});
          quo_d = {quo_q[19:0], 1'b1};
        end else begin
          rem_d = rem_sh[16:0];
          quo_d = {quo_q[19:0], 1'b0};
        end
        num_d = {num_q[19:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = T_MUL;
        end
      end
      T_MUL: begin
        ta_d    = prod[32:16];
        done_d  = 1'b1;
        state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    rr_q    <= rr_d;
    alpha_q <= alpha_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    zero_q  <= zero_d;
    ta_q    <= ta_d;
  end

  assign done_o = done_q;
  assign ta_o   = ta_q;

endmodule
